FILE: rtl/core/grss_pkg.sv
// Shared types and constants for the game record stream splitter.
package grss_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic ERR_BAD_OUTCOME = 1'b0;
    localparam logic ERR_TRUNCATED   = 1'b1;

    // Header layout: hash bytes, outcome byte, count bytes
    localparam int unsigned  HashBytes   = 8;
    localparam logic [3:0]   POS_OUTCOME = 4'd8;
    localparam logic [3:0]   POS_LAST    = 4'd12;
    localparam logic [1:0]   OUTCOME_MAX = 2'd2;

    localparam int unsigned  LenWidth    = 33;

    // One result word
    typedef struct packed {
        logic [1:0]          item_kind;
        logic [63:0]         record_hash;
        logic [1:0]          outcome;
        logic [31:0]         move_count;
        logic [LenWidth-1:0] payload_length;
        logic [7:0]          payload_byte;
        logic                last_of_record;
        logic                error_code;
    } result_t;

endpackage

FILE: rtl/core/grss_parser.sv
// Record parser: header accumulation, payload countdown and error detection.
module grss_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              end_of_stream,
    output logic              res_valid,
    output grss_pkg::result_t res
);

    grss_pkg::phase_t                   phase_reg, phase_next;
    logic [3:0]                         pos_reg, pos_next;
    logic [63:0]                        hash_reg, hash_next;
    logic [1:0]                         outcome_reg, outcome_next;
    logic                               outcome_bad_reg, outcome_bad_next;
    logic [23:0]                        count_reg, count_next;
    logic [grss_pkg::LenWidth-1:0]      remaining_reg, remaining_next;

    logic [31:0]                        full_count;
    logic [grss_pkg::LenWidth-1:0]      half_count;
    logic [grss_pkg::LenWidth-1:0]      header_len;
    logic                               payload_last;

    // Complete move count and packed payload length: (count >> 1) * 3 + 2 if odd
    assign full_count   = {count_reg, data_byte};
    assign half_count   = {2'b00, full_count[31:1]};
    assign header_len   = (half_count << 1) + half_count
                          + {{(grss_pkg::LenWidth-2){1'b0}}, full_count[0], 1'b0};
    assign payload_last = (remaining_reg <= {{(grss_pkg::LenWidth-1){1'b0}}, 1'b1});

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= grss_pkg::PH_HEADER;
            pos_reg         <= 4'd0;
            remaining_reg   <= '0;
        end else begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            remaining_reg   <= remaining_next;
        end
    end

    // Hold header fields
    always_ff @(posedge aclk) begin
        hash_reg        <= hash_next;
        outcome_reg     <= outcome_next;
        outcome_bad_reg <= outcome_bad_next;
        count_reg       <= count_next;
    end

    // Advance the parser on each accepted word
    always_comb begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        hash_next        = hash_reg;
        outcome_next     = outcome_reg;
        outcome_bad_next = outcome_bad_reg;
        count_next       = count_reg;
        remaining_next   = remaining_reg;
        res_valid        = 1'b0;
        res              = '0;

        unique case (phase_reg)
            grss_pkg::PH_PAYLOAD: begin
                if (in_fire) begin
                    res_valid = 1'b1;
                    if (end_of_stream && !payload_last) begin
                        res.item_kind  = grss_pkg::KIND_ERROR;
                        res.error_code = grss_pkg::ERR_TRUNCATED;
                        phase_next     = grss_pkg::PH_HALTED;
                    end else begin
                        res.item_kind      = grss_pkg::KIND_PAYLOAD;
                        res.payload_byte   = data_byte;
                        res.last_of_record = payload_last;
                        if (payload_last) begin
                            remaining_next = '0;
                            phase_next     = grss_pkg::PH_HEADER;
                        end else begin
                            remaining_next = remaining_reg
                                             - {{(grss_pkg::LenWidth-1){1'b0}}, 1'b1};
                        end
                    end
                end
            end
            grss_pkg::PH_HEADER: begin
                if (in_fire) begin
                    // Shift the byte into its header field
                    if (pos_reg < 4'(grss_pkg::HashBytes)) begin
                        hash_next = {hash_reg[55:0], data_byte};
                    end else if (pos_reg == grss_pkg::POS_OUTCOME) begin
                        outcome_next     = data_byte[1:0];
                        outcome_bad_next = (data_byte > {6'd0, grss_pkg::OUTCOME_MAX});
                    end else begin
                        count_next = {count_reg[15:0], data_byte};
                    end

                    if (pos_reg < grss_pkg::POS_LAST) begin
                        pos_next = pos_reg + 4'd1;
                        if (end_of_stream) begin
                            res_valid      = 1'b1;
                            res.item_kind  = grss_pkg::KIND_ERROR;
                            res.error_code = grss_pkg::ERR_TRUNCATED;
                            phase_next     = grss_pkg::PH_HALTED;
                        end
                    end else begin
                        // Header complete
                        pos_next  = 4'd0;
                        res_valid = 1'b1;
                        if (outcome_bad_reg) begin
                            res.item_kind  = grss_pkg::KIND_ERROR;
                            res.error_code = grss_pkg::ERR_BAD_OUTCOME;
                            phase_next     = grss_pkg::PH_HALTED;
                        end else if (end_of_stream && (header_len != '0)) begin
                            res.item_kind  = grss_pkg::KIND_ERROR;
                            res.error_code = grss_pkg::ERR_TRUNCATED;
                            phase_next     = grss_pkg::PH_HALTED;
                        end else begin
                            res.item_kind      = grss_pkg::KIND_HEADER;
                            res.record_hash    = hash_reg;
                            res.outcome        = outcome_reg;
                            res.move_count     = full_count;
                            res.payload_length = header_len;
                            res.last_of_record = (header_len == '0);
                            remaining_next     = header_len;
                            phase_next         = (header_len == '0) ? grss_pkg::PH_HEADER
                                                                    : grss_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            default: begin
                // Halted: drop every word until reset
            end
        endcase
    end

endmodule

FILE: rtl/core/game_record_stream_splitter_top.sv
// Game record stream splitter: top level with output register.
// A result appears on the m_ ports in the cycle after the word that causes it is accepted.
// Throughput: one input word per cycle while s_ready is high; the single output register keeps
// s_ready high whenever that register is empty or being drained.
// Reset (aresetn low, synchronous) returns the parser to the start of a header
// and empties the output register; after an error the block drops input until reset.
module game_record_stream_splitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_item_kind,
    output logic [63:0] m_record_hash,
    output logic [1:0]  m_outcome,
    output logic [31:0] m_move_count,
    output logic [32:0] m_payload_length,
    output logic [7:0]  m_payload_byte,
    output logic        m_last_of_record,
    output logic        m_error_code
);

    logic              in_fire;
    logic              res_valid;
    grss_pkg::result_t res;
    logic              out_valid_reg, out_valid_next;
    grss_pkg::result_t out_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    grss_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .data_byte     (s_data_byte),
        .end_of_stream (s_end_of_stream),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Refill or drain the output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            out_valid_next = in_fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result word
    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_item_kind      = out_reg.item_kind;
    assign m_record_hash    = out_reg.record_hash;
    assign m_outcome        = out_reg.outcome;
    assign m_move_count     = out_reg.move_count;
    assign m_payload_length = out_reg.payload_length;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_last_of_record = out_reg.last_of_record;
    assign m_error_code     = out_reg.error_code;

endmodule
